// ----- design/ahb_pkg.sv -----
package ahb_pkg;

    // bar height register is a fixed 11 bits wide
    localparam int BAR_W = 11;
    localparam int CFG_IDX_W = 3;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_ANIM_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAR_ROWS = 3'd4;

    // register reset values
    localparam int ANIM_ENABLE_RST = 1;
    localparam int DURATION_RST = 25;
    localparam int CURVE_MODE_RST = 1;
    localparam int SCREEN_ROWS_RST = 1080;
    localparam int BAR_ROWS_RST = 30;

    // easing curve codes
    localparam logic [1:0] CURVE_LINEAR = 2'd0;
    localparam logic [1:0] CURVE_EASE_OUT = 2'd1;
    localparam logic [1:0] CURVE_IN_OUT = 2'd2;
    localparam logic [1:0] CURVE_BOUNCE = 2'd3;

    // bounce arc scale 121/16, rounded half up
    localparam int BOUNCE_MUL = 121;
    localparam int BOUNCE_RND = 8;
    localparam int BOUNCE_SHIFT = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_PREP,
        ST_SQUARE,
        ST_CUBE,
        ST_EVAL,
        ST_LERP,
        ST_POS,
        ST_FIN
    } state_t;

endpackage

// ----- design/ahb_div.sv -----
module ahb_div #(
    parameter int NUM_W = 10,
    parameter int Q_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [NUM_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quot
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] den_reg, den_next;
    logic [Q_W-1:0]   quot_reg, quot_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [NUM_W:0]   shifted;
    logic             fit;

    // restoring division, one quotient bit per cycle, numerator below divisor
    always_comb
    begin
        shifted = {rem_reg, 1'b0};
        fit = shifted >= {1'b0, den_reg};
        rem_next = rem_reg;
        den_next = den_reg;
        quot_next = quot_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = num;
            den_next = den;
            quot_next = '0;
            cnt_next = CNT_W'(Q_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = fit ? NUM_W'(shifted - {1'b0, den_reg}) : shifted[NUM_W-1:0];
            quot_next = {quot_reg[Q_W-2:0], fit};
            cnt_next = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            den_reg <= '0;
            quot_reg <= '0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg <= rem_next;
            den_reg <= den_next;
            quot_reg <= quot_next;
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- design/ahb_mul.sv -----
module ahb_mul #(
    parameter int A_W = 28,
    parameter int B_W = 17,
    parameter int FRAC = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [A_W-1:0]        a,
    input  logic [B_W-1:0]        b,
    output logic [A_W+B_W-FRAC:0] rnd
);

    localparam int P_W = A_W + B_W + 1;

    logic [P_W-1:0] prod_reg, prod_next;
    logic [P_W-1:0] sum;

    assign prod_next = P_W'(a) * P_W'(b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_reg <= '0;
        else
            prod_reg <= prod_next;
    end

    // round half up on the registered product
    assign sum = prod_reg + (P_W'(1) << (FRAC - 1));
    assign rnd = sum[P_W-1:FRAC];

endmodule

// ----- design/autohide_bar_eased_slide.sv -----
// a jump or rest goes through ST_START and ST_FIN into the output register; an eased
// slide tick adds ST_DIV (the divider), ST_PREP, ST_SQUARE, ST_CUBE, ST_EVAL, ST_LERP,
// ST_POS, fewer for linear or bounce and for the tick that ends a slide
// one tick at a time; the next input is taken once the result is registered;
// the restoring divider (one bit a cycle) and shared multiplier set each tick's length
// reset: rst_n clears all state asynchronously; registers return to their defaults
module autohide_bar_eased_slide #(
    parameter int FRAC_BITS = 16,
    parameter int ROW_BITS = 12,
    parameter int TICK_BITS = 10,
    localparam int IN_W = ((ROW_BITS + 1 + 7) / 8) * 8,
    localparam int OUT_W = ((ROW_BITS + 2 + 7) / 8) * 8,
    localparam int CFG_W = (ROW_BITS > TICK_BITS)
        ? ((ROW_BITS > ahb_pkg::BAR_W) ? ROW_BITS : ahb_pkg::BAR_W)
        : ((TICK_BITS > ahb_pkg::BAR_W) ? TICK_BITS : ahb_pkg::BAR_W)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_W-1:0]               s_tdata,   // pointer_row, force_show
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_W-1:0]              m_tdata,   // bar_row, sliding, shown
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ahb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]              cfg_data
);

    localparam int FXW = ROW_BITS + FRAC_BITS;        // row position with fraction
    localparam int EW = FRAC_BITS + 1;                // progress and eased value, 0..1
    localparam int XW = (ROW_BITS > ahb_pkg::BAR_W) ? ROW_BITS : ahb_pkg::BAR_W;
    localparam int BNW = FRAC_BITS + 9;               // bounce arc before clamping
    localparam int MRW = FXW + EW - FRAC_BITS + 1;    // rounded multiplier result
    localparam int ONE_I = 1 << FRAC_BITS;

    localparam logic [EW-1:0] FX_ONE = EW'(ONE_I);
    localparam logic [EW-1:0] FX_HALF = EW'(ONE_I / 2);
    localparam logic [FXW:0]  POS_HALF = (FXW + 1)'(ONE_I / 2);

    // bounce breakpoints, centres and offsets rounded to nearest
    localparam logic [EW-1:0] BRK_1 = EW'((ONE_I * 4 + 5) / 11);
    localparam logic [EW-1:0] BRK_2 = EW'((ONE_I * 8 + 5) / 11);
    localparam logic [EW-1:0] BRK_3 = EW'((ONE_I * 10 + 5) / 11);
    localparam logic [EW-1:0] CTR_1 = EW'((ONE_I * 6 + 5) / 11);
    localparam logic [EW-1:0] CTR_2 = EW'((ONE_I * 9 + 5) / 11);
    localparam logic [EW-1:0] CTR_3 = EW'((ONE_I * 21 + 11) / 22);
    localparam logic [EW-1:0] OFS_1 = EW'((ONE_I * 3 + 2) / 4);
    localparam logic [EW-1:0] OFS_2 = EW'((ONE_I * 15 + 8) / 16);
    localparam logic [EW-1:0] OFS_3 = EW'((ONE_I * 63 + 32) / 64);

    // configuration registers
    logic                       anim_reg;
    logic [TICK_BITS-1:0]       dur_reg;
    logic [1:0]                 curve_reg;
    logic [ROW_BITS-1:0]        screen_reg;
    logic [ahb_pkg::BAR_W-1:0]  bar_reg;

    // animator state and sequencer scratch registers
    ahb_pkg::state_t            state_reg, state_next;
    logic                       primed_reg, primed_next;
    logic [ROW_BITS-1:0]        target_reg, target_next;
    logic [FXW-1:0]             start_reg, start_next;
    logic [FXW-1:0]             cur_reg, cur_next;
    logic [TICK_BITS-1:0]       elapsed_reg, elapsed_next;
    logic                       active_reg, active_next;
    logic [EW-1:0]              t_reg, t_next;
    logic [EW-1:0]              x_reg, x_next;
    logic [EW-1:0]              add_reg, add_next;
    logic [EW-1:0]              e_reg, e_next;
    logic [ROW_BITS-1:0]        row_reg, row_next;

    // output register, parts the sequencer from the result side
    logic                       out_valid_reg, out_valid_next;
    logic [ROW_BITS-1:0]        out_row_reg, out_row_next;
    logic                       out_sliding_reg, out_sliding_next;
    logic                       out_shown_reg, out_shown_next;

    // tick decision
    logic [ROW_BITS-1:0]        ptr;
    logic                       force_show;
    logic [ROW_BITS-1:0]        exp_row;
    logic [ROW_BITS-1:0]        hid_row;
    logic [ROW_BITS-1:0]        tgt0;
    logic [FXW-1:0]             cur0;
    logic                       expand;
    logic [ROW_BITS-1:0]        wanted;

    // divider and shared multiplier
    logic                       div_start;
    logic                       div_done;
    logic [FRAC_BITS-1:0]       div_quot;
    logic [FXW-1:0]             mul_a;
    logic [EW-1:0]              mul_b;
    logic [MRW-1:0]             mul_rnd;

    // datapath helpers
    logic [FXW-1:0]             tgt_fx;
    logic                       going_down;
    logic [FXW-1:0]             mag;
    logic [FXW-1:0]             delta;
    logic [FXW-1:0]             cur_calc;
    logic [FXW:0]               row_sum;
    logic [EW-1:0]              sq;
    logic [BNW-1:0]             bnc;
    logic [EW+1:0]              c4;

    assign cfg_ready = 1'b1;
    assign s_tready = (state_reg == ahb_pkg::ST_IDLE);

    assign m_tvalid = out_valid_reg;
    assign m_tdata = OUT_W'({out_shown_reg, out_sliding_reg, out_row_reg});

    // register file, takes a write on any cycle; the sender keeps writes to idle times
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anim_reg <= 1'(ahb_pkg::ANIM_ENABLE_RST);
            dur_reg <= TICK_BITS'(ahb_pkg::DURATION_RST);
            curve_reg <= 2'(ahb_pkg::CURVE_MODE_RST);
            screen_reg <= ROW_BITS'(ahb_pkg::SCREEN_ROWS_RST);
            bar_reg <= ahb_pkg::BAR_W'(ahb_pkg::BAR_ROWS_RST);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ahb_pkg::CFG_ANIM_ENABLE: anim_reg <= cfg_data[0];
                ahb_pkg::CFG_DURATION:    dur_reg <= cfg_data[TICK_BITS-1:0];
                ahb_pkg::CFG_CURVE_MODE:  curve_reg <= cfg_data[1:0];
                ahb_pkg::CFG_SCREEN_ROWS: screen_reg <= cfg_data[ROW_BITS-1:0];
                ahb_pkg::CFG_BAR_ROWS:    bar_reg <= cfg_data[ahb_pkg::BAR_W-1:0];
                default:                  ;
            endcase
        end
    end

    // expanded and hidden rows, both saturating at zero
    always_comb
    begin
        exp_row = (XW'(screen_reg) > XW'(bar_reg))
            ? ROW_BITS'(XW'(screen_reg) - XW'(bar_reg)) : '0;
        hid_row = (screen_reg >= ROW_BITS'(2)) ? screen_reg - ROW_BITS'(2) : '0;
    end

    // target decision with hysteresis; the first tick after reset starts off screen
    always_comb
    begin
        ptr = s_tdata[ROW_BITS-1:0];
        force_show = s_tdata[ROW_BITS];
        if (primed_reg)
        begin
            tgt0 = target_reg;
            cur0 = cur_reg;
        end
        else
        begin
            tgt0 = (screen_reg != '0) ? screen_reg - ROW_BITS'(1) : '0;
            cur0 = {tgt0, {FRAC_BITS{1'b0}}};
        end
        if (tgt0 == exp_row)
            expand = force_show || (ptr >= exp_row);
        else
            expand = force_show || (ptr >= hid_row);
        wanted = expand ? exp_row : hid_row;
    end

    // slide direction and distance
    always_comb
    begin
        tgt_fx = {target_reg, {FRAC_BITS{1'b0}}};
        going_down = tgt_fx < start_reg;
        mag = going_down ? start_reg - tgt_fx : tgt_fx - start_reg;
        delta = mul_rnd[FXW-1:0];
        if (!going_down)
            cur_calc = start_reg + delta;
        else
            cur_calc = (delta > start_reg) ? '0 : start_reg - delta;
        row_sum = {1'b0, cur_calc} + POS_HALF;
        sq = mul_rnd[EW-1:0];
        bnc = ((BNW'(sq) * BNW'(ahb_pkg::BOUNCE_MUL) + BNW'(ahb_pkg::BOUNCE_RND))
            >> ahb_pkg::BOUNCE_SHIFT) + BNW'(add_reg);
        c4 = {sq, 2'b00};
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        primed_next = primed_reg;
        target_next = target_reg;
        start_next = start_reg;
        cur_next = cur_reg;
        elapsed_next = elapsed_reg;
        active_next = active_reg;
        t_next = t_reg;
        x_next = x_reg;
        add_next = add_reg;
        e_next = e_reg;
        row_next = row_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_row_next = out_row_reg;
        out_sliding_next = out_sliding_reg;
        out_shown_next = out_shown_reg;
        div_start = 1'b0;
        mul_a = '0;
        mul_b = '0;

        case (state_reg)
            ahb_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    primed_next = 1'b1;
                    target_next = tgt0;
                    cur_next = cur0;
                    // a new target restarts the slide from where the bar is now
                    if (wanted != tgt0)
                    begin
                        start_next = cur0;
                        target_next = wanted;
                        elapsed_next = '0;
                        active_next = 1'b1;
                    end
                    state_next = ahb_pkg::ST_START;
                end
            end

            ahb_pkg::ST_START:
            begin
                if (active_reg && anim_reg)
                begin
                    // progress uses the count before this tick's increment
                    if ((dur_reg == '0) || (elapsed_reg >= dur_reg))
                    begin
                        t_next = FX_ONE;
                        active_next = 1'b0;
                        state_next = ahb_pkg::ST_PREP;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        state_next = ahb_pkg::ST_DIV;
                    end
                    if (elapsed_reg != '1)
                        elapsed_next = elapsed_reg + TICK_BITS'(1);
                end
                else
                begin
                    // resting or jumping straight to target
                    cur_next = tgt_fx;
                    active_next = 1'b0;
                    row_next = target_reg;
                    state_next = ahb_pkg::ST_FIN;
                end
            end

            ahb_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    t_next = EW'(div_quot);
                    state_next = ahb_pkg::ST_PREP;
                end
            end

            ahb_pkg::ST_PREP:
            begin
                state_next = ahb_pkg::ST_SQUARE;
                case (curve_reg)
                    ahb_pkg::CURVE_LINEAR:
                    begin
                        e_next = t_reg;
                        state_next = ahb_pkg::ST_LERP;
                    end
                    ahb_pkg::CURVE_EASE_OUT:
                        x_next = FX_ONE - t_reg;
                    ahb_pkg::CURVE_IN_OUT:
                        x_next = (t_reg < FX_HALF) ? t_reg : EW'((FX_ONE - t_reg) << 1);
                    ahb_pkg::CURVE_BOUNCE:
                    begin
                        // pick the arc, then distance from its centre
                        if (t_reg < BRK_1)
                        begin
                            x_next = t_reg;
                            add_next = '0;
                        end
                        else if (t_reg < BRK_2)
                        begin
                            x_next = (t_reg >= CTR_1) ? t_reg - CTR_1 : CTR_1 - t_reg;
                            add_next = OFS_1;
                        end
                        else if (t_reg < BRK_3)
                        begin
                            x_next = (t_reg >= CTR_2) ? t_reg - CTR_2 : CTR_2 - t_reg;
                            add_next = OFS_2;
                        end
                        else
                        begin
                            x_next = (t_reg >= CTR_3) ? t_reg - CTR_3 : CTR_3 - t_reg;
                            add_next = OFS_3;
                        end
                    end
                    default:
                        x_next = t_reg;
                endcase
            end

            ahb_pkg::ST_SQUARE:
            begin
                mul_a = FXW'(x_reg);
                mul_b = x_reg;
                state_next = ahb_pkg::ST_CUBE;
            end

            ahb_pkg::ST_CUBE:
            begin
                if (curve_reg == ahb_pkg::CURVE_BOUNCE)
                begin
                    e_next = (bnc > BNW'(FX_ONE)) ? FX_ONE : bnc[EW-1:0];
                    state_next = ahb_pkg::ST_LERP;
                end
                else
                begin
                    mul_a = FXW'(sq);
                    mul_b = x_reg;
                    state_next = ahb_pkg::ST_EVAL;
                end
            end

            ahb_pkg::ST_EVAL:
            begin
                // sq now holds the cube
                if (curve_reg == ahb_pkg::CURVE_IN_OUT && t_reg < FX_HALF)
                    e_next = (c4 > (EW + 2)'(FX_ONE)) ? FX_ONE : c4[EW-1:0];
                else if (curve_reg == ahb_pkg::CURVE_IN_OUT)
                    e_next = FX_ONE - (sq >> 1);
                else
                    e_next = (sq > FX_ONE) ? '0 : FX_ONE - sq;
                state_next = ahb_pkg::ST_LERP;
            end

            ahb_pkg::ST_LERP:
            begin
                mul_a = mag;
                mul_b = e_reg;
                state_next = ahb_pkg::ST_POS;
            end

            ahb_pkg::ST_POS:
            begin
                cur_next = cur_calc;
                row_next = (row_sum[FXW:FRAC_BITS] > (ROW_BITS + 1)'({ROW_BITS{1'b1}}))
                    ? '1 : row_sum[FRAC_BITS+ROW_BITS-1:FRAC_BITS];
                state_next = ahb_pkg::ST_FIN;
            end

            ahb_pkg::ST_FIN:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_row_next = row_reg;
                    out_sliding_next = active_reg;
                    out_shown_next = (target_reg == exp_row);
                    state_next = ahb_pkg::ST_IDLE;
                end
            end

            default:
                state_next = ahb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ahb_pkg::ST_IDLE;
            primed_reg <= 1'b0;
            target_reg <= '0;
            start_reg <= '0;
            cur_reg <= '0;
            elapsed_reg <= '0;
            active_reg <= 1'b0;
            t_reg <= '0;
            x_reg <= '0;
            add_reg <= '0;
            e_reg <= '0;
            row_reg <= '0;
            out_valid_reg <= 1'b0;
            out_row_reg <= '0;
            out_sliding_reg <= 1'b0;
            out_shown_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            primed_reg <= primed_next;
            target_reg <= target_next;
            start_reg <= start_next;
            cur_reg <= cur_next;
            elapsed_reg <= elapsed_next;
            active_reg <= active_next;
            t_reg <= t_next;
            x_reg <= x_next;
            add_reg <= add_next;
            e_reg <= e_next;
            row_reg <= row_next;
            out_valid_reg <= out_valid_next;
            out_row_reg <= out_row_next;
            out_sliding_reg <= out_sliding_next;
            out_shown_reg <= out_shown_next;
        end
    end

    // progress divider: elapsed << FRAC_BITS over duration
    ahb_div #(
        .NUM_W (TICK_BITS),
        .Q_W   (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (elapsed_reg),
        .den   (dur_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // one multiplier serves square, cube and interpolation
    ahb_mul #(
        .A_W   (FXW),
        .B_W   (EW),
        .FRAC  (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .a     (mul_a),
        .b     (mul_b),
        .rnd   (mul_rnd)
    );

endmodule

// ----- design/ahb_checker.sv -----
module ahb_checker #(
    parameter int ROW_BITS = 12,
    parameter int OUT_W = 16
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before its transaction");

    // a held result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata[ROW_BITS+1:0]))
        else $error("result payload changed while stalled");

    // each tick keeps the input closed at least through the START and FIN states
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input taken again too soon");

    // no result can come from a tick on the very next cycle
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared before the tick was processed");

endmodule

bind autohide_bar_eased_slide ahb_checker #(
    .ROW_BITS (ROW_BITS),
    .OUT_W    (OUT_W)
) u_ahb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
